/* rtl/box_downsample_2x2_macros.svh */
// Assertion macros shared by the checker.
`ifndef BOX_DOWNSAMPLE_2X2_MACROS_SVH
`define BOX_DOWNSAMPLE_2X2_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define BD2_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("box_downsample_2x2: assertion failed");

// Next-cycle implication, sampled on clock, off while reset is high.
`define BD2_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("box_downsample_2x2: assertion failed");

`endif

/* rtl/bd2_pkg.sv */
`timescale 1ns / 1ps
package bd2_pkg;

   localparam int MAX_COLS_DEF = 4096;

   localparam int PIX_W      = 8;
   localparam int SUM_W      = 9;           // sum of one horizontal pair
   localparam int BOX_W      = SUM_W + 2;   // 2x2 sum plus rounding
   localparam int ROW_W      = 16;
   localparam int CFG_COLS_W = 13;
   localparam int CFG_ROWS_W = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;

   localparam int COLS_RESET = 640;
   localparam int ROWS_RESET = 480;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_COLS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_ROWS = 1'd1;

   typedef struct packed {
      logic wr;     // store pair sum of an even row
      logic rd;     // fetch pair sum for an odd row, result follows
      logic last;   // block is the frame's last output
   } scan_ctl_type;

endpackage

/* rtl/bd2_line_mem.sv */
`timescale 1ns / 1ps
module bd2_line_mem #(
   parameter int DEPTH = bd2_pkg::MAX_COLS_DEF / 2,
   parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [IDX_W-1:0]          wr_idx,
   input  logic [bd2_pkg::SUM_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [IDX_W-1:0]          rd_idx,
   output logic [bd2_pkg::SUM_W-1:0] rd_data
);

   logic [bd2_pkg::SUM_W-1:0] mem [DEPTH];
   logic [bd2_pkg::SUM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/bd2_scan.sv */
`timescale 1ns / 1ps
module bd2_scan #(
   parameter int MAX_COLS = bd2_pkg::MAX_COLS_DEF,
   parameter int IDX_W    = (MAX_COLS / 2 > 1) ? $clog2(MAX_COLS / 2) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [bd2_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bd2_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           fire,
   input  logic [bd2_pkg::PIX_W-1:0]      pixel,
   output bd2_pkg::scan_ctl_type          ctl,
   output logic [IDX_W-1:0]               line_idx,
   output logic [bd2_pkg::SUM_W-1:0]      pair_sum
);

   localparam int CNT_W   = $clog2(MAX_COLS);
   localparam int COLS_W  = $clog2(MAX_COLS + 1);
   localparam int WIDE_W  = (COLS_W > bd2_pkg::CFG_COLS_W) ? COLS_W : bd2_pkg::CFG_COLS_W;
   localparam int COLS_RST = (bd2_pkg::COLS_RESET > MAX_COLS) ? MAX_COLS
                                                              : bd2_pkg::COLS_RESET;
   localparam int ROW_W   = bd2_pkg::ROW_W;

   // effective sizes, zero read as one, width capped at MAX_COLS
   logic [COLS_W-1:0] cols_ff, cols_in;
   logic [ROW_W-1:0]  rows_ff, rows_in;

   logic [CNT_W-1:0]         col_ff, col_in;
   logic [ROW_W-1:0]         row_ff, row_in;
   logic [bd2_pkg::PIX_W-1:0] held_ff, held_in;

   logic [bd2_pkg::CFG_COLS_W-1:0] cols_raw;
   logic [WIDE_W-1:0]              cols_raw_wide;
   logic [COLS_W-1:0]              col_w, cols_even;
   logic [ROW_W-1:0]               rows_even;
   logic                           in_pair, col_wrap, row_wrap;

   always_comb begin
      cols_raw      = csr_wdata[bd2_pkg::CFG_COLS_W-1:0];
      cols_raw_wide = WIDE_W'(cols_raw);
      cols_in       = cols_ff;
      rows_in       = rows_ff;
      if (csr_we) begin
         case (csr_index)
            bd2_pkg::CSR_IMAGE_COLS: begin
               if (cols_raw == '0) begin
                  cols_in = COLS_W'(1);
               end else if (cols_raw_wide > WIDE_W'(MAX_COLS)) begin
                  cols_in = COLS_W'(MAX_COLS);
               end else begin
                  cols_in = COLS_W'(cols_raw_wide);
               end
            end
            bd2_pkg::CSR_IMAGE_ROWS: begin
               if (csr_wdata[bd2_pkg::CFG_ROWS_W-1:0] == '0) begin
                  rows_in = ROW_W'(1);
               end else begin
                  rows_in = csr_wdata[bd2_pkg::CFG_ROWS_W-1:0];
               end
            end
            default: begin
               cols_in = cols_ff;
               rows_in = rows_ff;
            end
         endcase
      end
   end

   always_comb begin
      col_w     = COLS_W'(col_ff);
      cols_even = {cols_ff[COLS_W-1:1], 1'b0};
      rows_even = {rows_ff[ROW_W-1:1], 1'b0};
      in_pair   = col_ff[0] && (col_w < cols_even);
      col_wrap  = ((COLS_W + 1)'(col_w) + (COLS_W + 1)'(1)) >= (COLS_W + 1)'(cols_ff);
      row_wrap  = ((ROW_W + 1)'(row_ff) + (ROW_W + 1)'(1)) >= (ROW_W + 1)'(rows_ff);

      pair_sum  = bd2_pkg::SUM_W'(held_ff) + bd2_pkg::SUM_W'(pixel);
      line_idx  = IDX_W'(col_ff >> 1);

      ctl.wr    = fire && in_pair && !row_ff[0];
      ctl.rd    = fire && in_pair && row_ff[0] && (row_ff < rows_even);
      ctl.last  = (col_w == cols_even - COLS_W'(1)) && (row_ff == rows_even - ROW_W'(1));

      col_in  = col_ff;
      row_in  = row_ff;
      held_in = held_ff;
      if (fire) begin
         if (!col_ff[0]) begin
            held_in = pixel;
         end
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= COLS_W'(COLS_RST);
         rows_ff <= ROW_W'(bd2_pkg::ROWS_RESET);
         col_ff  <= '0;
         row_ff  <= '0;
         held_ff <= '0;
      end else begin
         cols_ff <= cols_in;
         rows_ff <= rows_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
         held_ff <= held_in;
      end
   end

endmodule

/* rtl/box_downsample_2x2.sv */
`timescale 1ns / 1ps
// 2x2 box-filter downsampler for 8-bit grey frames. Pixels stream in on
// req_ in raster order, one word per cycle; each output word on rsp_ is the
// rounded mean (sum + 2) >> 2 of one 2x2 block, emitted at the odd-row,
// odd-column pixel that closes the block, with rsp_tlast on the frame's last
// block. An odd right column or bottom row gives no output. Frame size is set
// through csr_ (index 0: width, capped at MAX_COLS; index 1: height; zero acts
// as one) and must only change while the block is idle. Throughput is one
// pixel per clock unless rsp_ stalls, through stage 1 and the output register.
// The pace is set by the single-port-per-direction line memory of MAX_COLS/2
// pair sums: one write (even rows) or one read (odd rows) per pixel pair.
// req_tready drops only while an output word waits on rsp_tready.
module box_downsample_2x2 #(
   parameter int MAX_COLS = bd2_pkg::MAX_COLS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // input pixels
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] pixel_in
   // downsampled pixels
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,   // [7:0] pixel_out
   output logic                           rsp_tlast,   // frame_last
   // configuration writes
   input  logic                           csr_we,
   input  logic [bd2_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bd2_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int DEPTH = MAX_COLS / 2;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   bd2_pkg::scan_ctl_type     ctl;
   logic [IDX_W-1:0]          line_idx;
   logic [bd2_pkg::SUM_W-1:0] pair_sum;
   logic [bd2_pkg::SUM_W-1:0] line_rd_data;
   logic                      fire;
   logic                      advance;

   // stage 1: waits for the line memory read
   logic                      s1_valid_ff, s1_valid_in;
   logic [bd2_pkg::SUM_W-1:0] s1_pair_ff, s1_pair_in;
   logic                      s1_last_ff, s1_last_in;

   // output word register
   logic                      out_valid_ff, out_valid_in;
   logic [bd2_pkg::PIX_W-1:0] out_pix_ff, out_pix_in;
   logic                      out_last_ff, out_last_in;
   logic [bd2_pkg::BOX_W-1:0] box_sum;

   // Whole pipe moves together; it only holds when the output word is stuck.
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign fire       = req_tvalid && advance;

   bd2_scan #(
      .MAX_COLS (MAX_COLS),
      .IDX_W    (IDX_W)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fire      (fire),
      .pixel     (req_tdata),
      .ctl       (ctl),
      .line_idx  (line_idx),
      .pair_sum  (pair_sum)
   );

   // Even rows write, odd rows read, and any row using the memory lasts at least
   // two accepted words, so a read never meets a write to the same entry in flight.
   bd2_line_mem #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (ctl.wr),
      .wr_idx  (line_idx),
      .wr_data (pair_sum),
      .rd_en   (ctl.rd),
      .rd_idx  (line_idx),
      .rd_data (line_rd_data)
   );

   always_comb begin
      box_sum = bd2_pkg::BOX_W'(line_rd_data) + bd2_pkg::BOX_W'(s1_pair_ff)
              + bd2_pkg::BOX_W'(2);

      s1_valid_in  = s1_valid_ff;
      s1_pair_in   = s1_pair_ff;
      s1_last_in   = s1_last_ff;
      out_valid_in = out_valid_ff;
      out_pix_in   = out_pix_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         s1_valid_in  = ctl.rd;
         s1_pair_in   = pair_sum;
         s1_last_in   = ctl.last;
         out_valid_in = s1_valid_ff;
         out_pix_in   = box_sum[bd2_pkg::BOX_W-2:2];   // round-half-up of sum/4
         out_last_in  = s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pair_ff  <= s1_pair_in;
      s1_last_ff  <= s1_last_in;
      out_pix_ff  <= out_pix_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pix_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

/* rtl/bd2_checker.sv */
`timescale 1ns / 1ps
`include "box_downsample_2x2_macros.svh"
module bd2_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // a stalled output word holds
   `BD2_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // input side only back-pressures while an output word is stuck
   `BD2_ASSERT_IMPL(a_ready_free, !rsp_tvalid, req_tready)
   `BD2_ASSERT_IMPL(a_ready_why, !req_tready, rsp_tvalid && !rsp_tready)

   // a fresh output word traces back through stage 1 to an accepted word
   `BD2_ASSERT_IMPL(a_rsp_cause, $rose(rsp_tvalid), $past(req_tvalid && req_tready, 2))

endmodule

bind box_downsample_2x2 bd2_checker u_bd2_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
